/* rtl/core/bbrt_pkg.sv */
`default_nettype none
package bbrt_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 8;
  localparam int FUNC_W    = 2;
  localparam int OUT_CNT_W = 5;
  localparam int ENT_W     = 2 * ADDR_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD = 2'd0,
    FN_RMV = 2'd1,
    FN_HIT = 2'd2,
    FN_OVL = 2'd3
  } func_t;

  typedef struct packed {
    logic covered;
    logic brd_end;
    logic brd_start;
    logic overlap;
    logic single;
    logic at_start;
    logic at_end;
  } cmp_t;

endpackage
`default_nettype wire

/* rtl/core/bad_block_range_table_top.sv */
// Each slot below the used count passes through S_RD, which issues the table RAM read,
// and then S_EV, which compares; S_FIN follows, and S_WR2 after it for a split.
// A new item is not taken while busy; start is taken again
// in the cycle out_valid shows.
// The receiver cannot stall: out_valid is a single-cycle strobe.
// Reset (rst_n low, synchronous) clears the sequencer, active marks and used count.
`default_nettype none
module bad_block_range_table_top #(
  parameter int SLOTS = bbrt_pkg::SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bbrt_pkg::FUNC_W-1:0]       in_func,
  input  wire logic [bbrt_pkg::ADDR_W-1:0]       in_block_addr,
  input  wire logic [bbrt_pkg::LEN_W-1:0]        in_span_len,
  output logic                                   out_valid,
  output logic                                   out_found,
  output logic [bbrt_pkg::OUT_CNT_W-1:0]         out_slots_used
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int AW    = bbrt_pkg::ADDR_W;
  localparam int OW    = bbrt_pkg::OUT_CNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_FIN  = 5'b01000,
    S_WR2  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  bbrt_pkg::func_t           func_r;
  logic [AW-1:0]             addr_r;
  logic [bbrt_pkg::LEN_W-1:0] len_r;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          used_r, used_nxt;
  logic [SLOTS-1:0]          act_r, act_nxt;
  logic                      m_found_r, m_found_nxt;
  logic [IDX_W-1:0]          m_idx_r, m_idx_nxt;
  bbrt_pkg::cmp_t            m_cmp_r, m_cmp_nxt;
  logic [bbrt_pkg::ENT_W-1:0] m_ent_r, m_ent_nxt;
  logic                      f_found_r, f_found_nxt;
  logic [IDX_W-1:0]          f_idx_r, f_idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [OW-1:0]             out_cnt_r, out_cnt_nxt;

  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [bbrt_pkg::ENT_W-1:0] wdata;
  logic [bbrt_pkg::ENT_W-1:0] rdata;
  bbrt_pkg::cmp_t            cmp;

  logic [IDX_W-1:0]          cur;
  logic [CNT_W-1:0]          idx_inc;
  logic                      cur_act;
  logic                      match;
  logic [AW-1:0]             m_s;
  logic [AW-1:0]             m_e;
  logic [IDX_W-1:0]          tgt_idx;
  logic                      tgt_ok;
  logic [CNT_W-1:0]          used_inc;
  logic [OW+CNT_W-1:0]       used_ext;
  logic                      is_query;

  assign cur      = idx_r[IDX_W-1:0];
  assign idx_inc  = idx_r + 1'b1;
  assign cur_act  = act_r[cur];
  assign m_s      = m_ent_r[bbrt_pkg::ENT_W-1:AW];
  assign m_e      = m_ent_r[AW-1:0];
  assign tgt_idx  = f_found_r ? f_idx_r : used_r[IDX_W-1:0];
  assign tgt_ok   = f_found_r || (used_r < CNT_W'(SLOTS));
  assign used_inc = used_r + 1'b1;
  assign is_query = (func_r == bbrt_pkg::FN_HIT) || (func_r == bbrt_pkg::FN_OVL);

  bbrt_ram #(
    .WIDTH (bbrt_pkg::ENT_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cur),
    .rdata (rdata)
  );

  bbrt_cmp u_cmp (
    .addr     (addr_r),
    .span_len (len_r),
    .ent      (rdata),
    .res      (cmp)
  );

  always_comb begin
    case (func_r)
      bbrt_pkg::FN_ADD: match = cur_act && (cmp.covered || cmp.brd_end || cmp.brd_start);
      bbrt_pkg::FN_OVL: match = cur_act && cmp.overlap;
      default:          match = cur_act && cmp.covered;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    act_nxt       = act_r;
    m_found_nxt   = m_found_r;
    m_idx_nxt     = m_idx_r;
    m_cmp_nxt     = m_cmp_r;
    m_ent_nxt     = m_ent_r;
    f_found_nxt   = f_found_r;
    f_idx_nxt     = f_idx_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_cnt_nxt   = out_cnt_r;
    we            = 1'b0;
    waddr         = m_idx_r;
    wdata         = m_ent_r;
    used_ext      = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt     = '0;
          m_found_nxt = 1'b0;
          f_found_nxt = 1'b0;
          state_nxt   = (used_r == '0) ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (match && !m_found_r) begin
          m_found_nxt = 1'b1;
          m_idx_nxt   = cur;
          m_cmp_nxt   = cmp;
          m_ent_nxt   = rdata;
        end
        if (!cur_act && !f_found_r) begin
          f_found_nxt = 1'b1;
          f_idx_nxt   = cur;
        end
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc == used_r) ? S_FIN : S_RD;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
        case (func_r)
          bbrt_pkg::FN_ADD: begin
            if (m_found_r) begin
              if (!m_cmp_r.covered) begin
                we    = 1'b1;
                wdata = m_cmp_r.brd_end ? {m_s, addr_r} : {addr_r, m_e};
              end
            end else if (tgt_ok) begin
              we             = 1'b1;
              waddr          = tgt_idx;
              wdata          = {addr_r, addr_r};
              act_nxt[tgt_idx] = 1'b1;
              if (!f_found_r) begin
                used_nxt = used_inc;
              end
            end
          end
          bbrt_pkg::FN_RMV: begin
            if (m_found_r) begin
              if (m_cmp_r.single) begin
                act_nxt[m_idx_r] = 1'b0;
              end else if (m_cmp_r.at_start) begin
                we    = 1'b1;
                wdata = {m_s + 1'b1, m_e};
              end else if (m_cmp_r.at_end) begin
                we    = 1'b1;
                wdata = {m_s, m_e - 1'b1};
              end else if (tgt_ok) begin
                we               = 1'b1;
                waddr            = tgt_idx;
                wdata            = {addr_r + 1'b1, m_e};
                act_nxt[tgt_idx] = 1'b1;
                if (!f_found_r) begin
                  used_nxt = used_inc;
                end
                state_nxt = S_WR2;
              end
            end
          end
          default: begin
          end
        endcase
        if (state_nxt == S_IDLE) begin
          used_ext      = {{OW{1'b0}}, used_nxt};
          out_valid_nxt = 1'b1;
          out_found_nxt = m_found_r && is_query;
          out_cnt_nxt   = used_ext[OW-1:0];
        end
      end
      S_WR2: begin
        we            = 1'b1;
        wdata         = {m_s, addr_r - 1'b1};
        used_ext      = {{OW{1'b0}}, used_r};
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b0;
        out_cnt_nxt   = used_ext[OW-1:0];
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      func_r <= bbrt_pkg::func_t'(in_func);
      addr_r <= in_block_addr;
      len_r  <= in_span_len;
    end
    idx_r       <= idx_nxt;
    m_found_r   <= m_found_nxt;
    m_idx_r     <= m_idx_nxt;
    m_cmp_r     <= m_cmp_nxt;
    m_ent_r     <= m_ent_nxt;
    f_found_r   <= f_found_nxt;
    f_idx_r     <= f_idx_nxt;
    out_found_r <= out_found_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_slots_used = out_cnt_r;

endmodule
`default_nettype wire

/* rtl/core/bbrt_ram.sv */
`default_nettype none
module bbrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/core/bbrt_cmp.sv */
`default_nettype none
module bbrt_cmp (
  input  wire logic [bbrt_pkg::ADDR_W-1:0] addr,
  input  wire logic [bbrt_pkg::LEN_W-1:0]  span_len,
  input  wire logic [bbrt_pkg::ENT_W-1:0]  ent,
  output bbrt_pkg::cmp_t                   res
);

  logic [bbrt_pkg::ADDR_W-1:0] s;
  logic [bbrt_pkg::ADDR_W-1:0] e;
  logic [bbrt_pkg::ADDR_W-1:0] top;
  logic [bbrt_pkg::ADDR_W-1:0] e_inc;
  logic [bbrt_pkg::ADDR_W-1:0] a_inc;

  assign s     = ent[bbrt_pkg::ENT_W-1:bbrt_pkg::ADDR_W];
  assign e     = ent[bbrt_pkg::ADDR_W-1:0];
  assign top   = addr + {{(bbrt_pkg::ADDR_W-bbrt_pkg::LEN_W){1'b0}}, span_len};
  assign e_inc = e + 1'b1;
  assign a_inc = addr + 1'b1;

  always_comb begin
    res.covered   = (addr >= s) && (addr <= e);
    res.brd_end   = (addr == e_inc);
    res.brd_start = (a_inc == s);
    res.overlap   = (top > s) && (addr <= e);
    res.single    = (s == e);
    res.at_start  = (addr == s);
    res.at_end    = (addr == e);
  end

endmodule
`default_nettype wire

/* rtl/core/bbrt_chk.sv */
`default_nettype none
module bbrt_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic                          out_found,
  input wire logic [bbrt_pkg::OUT_CNT_W-1:0] out_slots_used
);

  localparam int CW = bbrt_pkg::OUT_CNT_W;

  logic [CW-1:0] last_cnt_r;
  logic [CW-1:0] cnt_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
    end else if (out_valid) begin
      last_cnt_r <= out_slots_used;
    end
  end

  assign cnt_step = out_slots_used - last_cnt_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("item finished without a result");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!$isunknown(out_found) && (cnt_step == '0 || cnt_step == CW'(1))))
    else $error("slot count moved by more than one");

endmodule

bind bad_block_range_table_top bbrt_chk u_bbrt_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_found      (out_found),
  .out_slots_used (out_slots_used)
);
`default_nettype wire
